// ===== hdl/uvsv_pkg.sv =====
// ----------------------------------------------------------------------------
// uvsv_pkg
// Types, constants and arithmetic helpers of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvsv_pkg;

  localparam int MAX_QUALITY = 64;

  // register indexes of the configuration port
  localparam logic [0:0] CFG_QUALITY = 1'b0;
  localparam logic [0:0] CFG_RADIUS  = 1'b1;

  // quarter turn in units of 2^-24 turn
  localparam logic [23:0] QUARTER = 24'h40_0000;

  // odd sine polynomial, Q30 coefficients
  localparam logic [31:0] A1 = 32'd1686629713;
  localparam logic [31:0] A3 = 32'd693598668;
  localparam logic [31:0] A5 = 32'd85569306;
  localparam logic [31:0] A7 = 32'd5026995;
  localparam logic [31:0] A9 = 32'd172272;

  typedef struct packed {
    logic signed [7:0] lat_step;
    logic [8:0]        lon_step;
  } step_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        vertex_index;
    logic [8:0]         row_stride;
  } vertex_t;

  // floor(2^32 / (2q)) + 1, reciprocal of the divisor 2q
  function automatic logic [31:0] recip(input logic [6:0] q);
    logic [31:0] r;
    unique case (q)
      7'd1:  r = 32'd2147483649;
      7'd2:  r = 32'd1073741825;
      7'd3:  r = 32'd715827883;
      7'd4:  r = 32'd536870913;
      7'd5:  r = 32'd429496730;
      7'd6:  r = 32'd357913942;
      7'd7:  r = 32'd306783379;
      7'd8:  r = 32'd268435457;
      7'd9:  r = 32'd238609295;
      7'd10: r = 32'd214748365;
      7'd11: r = 32'd195225787;
      7'd12: r = 32'd178956971;
      7'd13: r = 32'd165191050;
      7'd14: r = 32'd153391690;
      7'd15: r = 32'd143165577;
      7'd16: r = 32'd134217729;
      7'd17: r = 32'd126322568;
      7'd18: r = 32'd119304648;
      7'd19: r = 32'd113025456;
      7'd20: r = 32'd107374183;
      7'd21: r = 32'd102261127;
      7'd22: r = 32'd97612894;
      7'd23: r = 32'd93368855;
      7'd24: r = 32'd89478486;
      7'd25: r = 32'd85899346;
      7'd26: r = 32'd82595525;
      7'd27: r = 32'd79536432;
      7'd28: r = 32'd76695845;
      7'd29: r = 32'd74051161;
      7'd30: r = 32'd71582789;
      7'd31: r = 32'd69273667;
      7'd32: r = 32'd67108865;
      7'd33: r = 32'd65075263;
      7'd34: r = 32'd63161284;
      7'd35: r = 32'd61356676;
      7'd36: r = 32'd59652324;
      7'd37: r = 32'd58040099;
      7'd38: r = 32'd56512728;
      7'd39: r = 32'd55063684;
      7'd40: r = 32'd53687092;
      7'd41: r = 32'd52377650;
      7'd42: r = 32'd51130564;
      7'd43: r = 32'd49941481;
      7'd44: r = 32'd48806447;
      7'd45: r = 32'd47721859;
      7'd46: r = 32'd46684428;
      7'd47: r = 32'd45691142;
      7'd48: r = 32'd44739243;
      7'd49: r = 32'd43826197;
      7'd50: r = 32'd42949673;
      7'd51: r = 32'd42107523;
      7'd52: r = 32'd41297763;
      7'd53: r = 32'd40518560;
      7'd54: r = 32'd39768216;
      7'd55: r = 32'd39045158;
      7'd56: r = 32'd38347923;
      7'd57: r = 32'd37674977;
      7'd58: r = 32'd37025581;
      7'd59: r = 32'd36398028;
      7'd60: r = 32'd35791395;
      7'd61: r = 32'd35204650;
      7'd62: r = 32'd34636834;
      7'd63: r = 32'd34087043;
      default: r = 32'd33554433;
    endcase
    return r;
  endfunction

  // Q15 times Q15, rounded to nearest with ties away from zero
  function automatic logic signed [16:0] rmul15(input logic signed [16:0] a,
                                                input logic signed [16:0] b);
    logic [16:0] ma;
    logic [16:0] mb;
    logic [33:0] p;
    logic [16:0] m;
    ma = a[16] ? 17'(-a) : 17'(a);
    mb = b[16] ? 17'(-b) : 17'(b);
    p  = 34'(ma) * 34'(mb) + 34'd16384;
    m  = p[31:15];
    return (a[16] ^ b[16]) ? -$signed(m) : $signed(m);
  endfunction

  // Q15 times unsigned Q8.8 radius, rounded to Q8.15
  function automatic logic signed [24:0] rmul8(input logic signed [16:0] a,
                                               input logic [15:0] r);
    logic [16:0] ma;
    logic [33:0] p;
    logic [24:0] m;
    ma = a[16] ? 17'(-a) : 17'(a);
    p  = 34'(ma) * 34'(r) + 34'd128;
    m  = p[32:8];
    return a[16] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] s;
    if (v > 17'sd32767) begin
      s = 16'sd32767;
    end else if (v < -17'sd32768) begin
      s = -16'sd32768;
    end else begin
      s = v[15:0];
    end
    return s;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] s;
    if (v > 25'sd8388607) begin
      s = 24'sd8388607;
    end else if (v < -25'sd8388608) begin
      s = -24'sd8388608;
    end else begin
      s = v[23:0];
    end
    return s;
  endfunction

endpackage

// ===== hdl/uv_sphere_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Turns one latitude/longitude grid step into a sphere vertex.
// ----------------------------------------------------------------------------
// Takes a grid point (lat_step in -Q..Q, lon_step in 0..4Q; out-of-range
// steps are clamped) and returns the vertex normal, position, tangent,
// texcoords, flat index and row stride. One vertex enters and one leaves
// per cycle while the output is not stalled. The pipeline holds the
// reciprocal divider and the six chained multiplies of the sine polynomial.
// A stall at the output freezes the whole pipeline. Write quality and
// radius only while no transfer is in flight.
module uv_sphere_vertex_generator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_valid,
  output logic                 step_ready,
  input  uvsv_pkg::step_t      step,
  output logic                 vertex_valid,
  input  logic                 vertex_ready,
  output uvsv_pkg::vertex_t    vertex,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_addr,
  input  logic [15:0]          cfg_data
);
  import uvsv_pkg::*;

  localparam int LAST = 12;

  typedef struct packed {
    logic [15:0] idx;
    logic [8:0]  stride;
    logic [15:0] u;
    logic [15:0] v;
  } side_t;

  logic [6:0]  quality;
  logic [15:0] sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      quality       <= 7'd16;
      sphere_radius <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_QUALITY: quality       <= cfg_data[6:0];
        CFG_RADIUS:  sphere_radius <= cfg_data;
        default:     ;
      endcase
    end
  end

  logic [LAST:0] vld;
  logic          adv;

  assign adv          = !vld[LAST] || vertex_ready;
  assign step_ready   = adv && !rst;
  assign vertex_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], step_valid};
    end
  end

  // clamp and divider operands
  logic [6:0]        qv;
  logic signed [7:0] qs;
  logic signed [7:0] lat_c;
  logic [8:0]        q4;
  logic [8:0]        lon_c;
  logic [6:0]        alat;
  logic [7:0]        latp;
  logic [31:0]       num_in [4];

  always_comb begin
    if (quality == 7'd0) begin
      qv = 7'd1;
    end else if (quality > 7'(MAX_QUALITY)) begin
      qv = 7'(MAX_QUALITY);
    end else begin
      qv = quality;
    end
    qs = $signed({1'b0, qv});
    if (step.lat_step < -qs) begin
      lat_c = -qs;
    end else if (step.lat_step > qs) begin
      lat_c = qs;
    end else begin
      lat_c = step.lat_step;
    end
    q4    = {qv, 2'b00};
    lon_c = (step.lon_step > q4) ? q4 : step.lon_step;
    alat  = lat_c[7] ? 7'(-lat_c) : lat_c[6:0];
    latp  = 8'(lat_c + qs);
    num_in[0] = 32'({alat, 23'd0}) + 32'(qv);
    num_in[1] = 32'({lon_c, 23'd0}) + 32'(qv);
    num_in[2] = 32'({lon_c, 14'd0}) + 32'(qv);
    num_in[3] = 32'({latp, 15'd0}) + 32'(qv);
  end

  // stage 0
  logic [31:0] n0 [4];
  logic [31:0] rcp0;
  logic [7:0]  d0;
  logic        neg0;
  logic [7:0]  latp0;
  logic [8:0]  lon0;
  logic [8:0]  stride0;
  // stage 1
  logic [31:0] q1 [4];
  logic [31:0] n1 [4];
  logic [7:0]  d1;
  logic        neg1;
  // stage 2
  logic [39:0] m2 [4];
  logic [31:0] q2 [4];
  logic [31:0] n2 [4];
  logic [7:0]  d2;
  logic        neg2;
  // stage 3
  logic [23:0] phl3;
  logic [23:0] pho3;
  logic        neg3;
  // stages 4..10
  logic [30:0] t30p  [4:9][4];
  logic        sneg  [4:9][4];
  logic [30:0] t2p   [5:9][4];
  logic [31:0] poly  [6:9][4];
  logic signed [16:0] trig10 [4];
  // stage 11
  logic signed [16:0] nx11;
  logic signed [16:0] ny11;
  logic signed [16:0] nz11;

  side_t side [1:11];

  // quotient correction after the reciprocal estimate
  logic [31:0] qc [4];
  logic signed [40:0] diff;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff = $signed({9'd0, n2[i]}) - $signed({1'b0, m2[i]});
      if (diff < 0) begin
        qc[i] = q2[i] - 32'd1;
      end else if (diff >= $signed(41'(d2))) begin
        qc[i] = q2[i] + 32'd1;
      end else begin
        qc[i] = q2[i];
      end
    end
  end

  // quadrant folding of the four phases
  logic [23:0] ph [4];
  logic [22:0] tq [4];

  always_comb begin
    ph[0] = phl3;
    ph[1] = phl3 + QUARTER;
    ph[2] = pho3;
    ph[3] = pho3 + QUARTER;
    for (int i = 0; i < 4; i++) begin
      tq[i] = ph[i][22] ? (23'h40_0000 - {1'b0, ph[i][21:0]}) : {1'b0, ph[i][21:0]};
    end
  end

  logic [63:0] sq5 [4];
  logic [63:0] pr6 [4];
  logic [63:0] prk [7:9][4];
  logic [63:0] fin [4];
  logic [31:0] coef [7:9];
  logic [16:0] mag [4];

  always_comb begin
    coef[7] = A5;
    coef[8] = A3;
    coef[9] = A1;
    for (int i = 0; i < 4; i++) begin
      sq5[i] = 64'(t30p[4][i]) * 64'(t30p[4][i]);
      pr6[i] = 64'(t2p[5][i]) * 64'(A9);
      for (int s = 7; s <= 9; s++) begin
        prk[s][i] = 64'(t2p[s-1][i]) * 64'(poly[s-1][i]);
      end
      fin[i] = 64'(t30p[9][i]) * 64'(poly[9][i]);
      mag[i] = 17'((fin[i][60:30] + 31'd16384) >> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 0: clamp, numerators, reciprocal
      for (int i = 0; i < 4; i++) begin
        n0[i] <= num_in[i];
      end
      rcp0    <= recip(qv);
      d0      <= {qv, 1'b0};
      neg0    <= lat_c[7];
      latp0   <= latp;
      lon0    <= lon_c;
      stride0 <= 9'({qv, 2'b00}) + 9'd1;

      // stage 1: quotient estimate, vertex index
      for (int i = 0; i < 4; i++) begin
        q1[i] <= 32'((64'(n0[i]) * 64'(rcp0)) >> 32);
        n1[i] <= n0[i];
      end
      d1               <= d0;
      neg1             <= neg0;
      side[1].idx      <= 16'(17'(latp0) * 17'(stride0) + 17'(lon0));
      side[1].stride   <= stride0;
      side[1].u        <= '0;
      side[1].v        <= '0;

      // stage 2: back-multiply for the remainder check
      for (int i = 0; i < 4; i++) begin
        m2[i] <= 40'(q1[i]) * 40'(d1);
        q2[i] <= q1[i];
        n2[i] <= n1[i];
      end
      d2      <= d1;
      neg2    <= neg1;
      side[2] <= side[1];

      // stage 3: corrected quotients
      phl3           <= qc[0][23:0];
      pho3           <= qc[1][23:0];
      neg3           <= neg2;
      side[3].idx    <= side[2].idx;
      side[3].stride <= side[2].stride;
      side[3].u      <= qc[2][15:0];
      side[3].v      <= qc[3][15:0];

      // stage 4: fold into the first quadrant
      for (int i = 0; i < 4; i++) begin
        t30p[4][i] <= {tq[i], 8'd0};
        sneg[4][i] <= ph[i][23] ^ ((i == 0) && neg3);
      end
      side[4] <= side[3];

      // stages 5..9: square, then Horner steps
      for (int i = 0; i < 4; i++) begin
        t2p[5][i]  <= sq5[i][60:30];
        poly[6][i] <= A7 - 32'(pr6[i] >> 30);
        for (int s = 7; s <= 9; s++) begin
          poly[s][i] <= coef[s] - 32'(prk[s][i] >> 30);
        end
        for (int s = 6; s <= 9; s++) begin
          t2p[s][i] <= t2p[s-1][i];
        end
        for (int s = 5; s <= 9; s++) begin
          t30p[s][i] <= t30p[s-1][i];
          sneg[s][i] <= sneg[s-1][i];
        end
      end
      for (int s = 5; s <= 11; s++) begin
        side[s] <= side[s-1];
      end

      // stage 10: final product and rounding to Q15
      for (int i = 0; i < 4; i++) begin
        trig10[i] <= sneg[9][i] ? -$signed(mag[i]) : $signed(mag[i]);
      end

      // stage 11: normal
      nx11 <= rmul15(trig10[1], trig10[3]);
      ny11 <= trig10[0];
      nz11 <= rmul15(trig10[1], trig10[2]);

      // stage 12: position and output register
      vertex.normal_x     <= sat16(nx11);
      vertex.normal_y     <= sat16(ny11);
      vertex.normal_z     <= sat16(nz11);
      vertex.pos_x        <= sat24(rmul8(nx11, sphere_radius));
      vertex.pos_y        <= sat24(rmul8(ny11, sphere_radius));
      vertex.pos_z        <= sat24(rmul8(nz11, sphere_radius));
      vertex.tangent_x    <= sat16(17'(-nz11));
      vertex.tangent_z    <= sat16(nx11);
      vertex.tex_u        <= side[11].u;
      vertex.tex_v        <= side[11].v;
      vertex.vertex_index <= side[11].idx;
      vertex.row_stride   <= side[11].stride;
    end
  end

endmodule
